/* rtl/mcle_pkg.sv */
// Shared types and constants for the Morse code LED encoder.
// No dependencies; compiled first.
`default_nettype none

package mcle_pkg;

	// Text symbol codes carried with each segment
	localparam logic [2:0] TXT_NONE    = 3'd0;
	localparam logic [2:0] TXT_DOT     = 3'd1;
	localparam logic [2:0] TXT_DASH    = 3'd2;
	localparam logic [2:0] TXT_SPACE   = 3'd3;
	localparam logic [2:0] TXT_NEWLINE = 3'd4;

	localparam logic [1:0] UNITS_NONE = 2'd0;
	localparam logic [1:0] UNITS_DOT  = 2'd1;
	localparam logic [1:0] UNITS_DASH = 2'd3;

	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	localparam int NUM_LETTERS = 26;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);

	// Symbol list of one letter: count, and dash flags with the first symbol in bit 3
	typedef struct packed {
		logic [2:0] len;
		logic [3:0] dash;
	} glyph_t;

	// Decoded form of the on/off pattern ROM (flag 1 = dash, 3 units on; flag 0 = dot, 1 unit on)
	localparam glyph_t GLYPH_TAB [NUM_LETTERS] = '{
		'{3'd2, 4'b0100}, // A .-
		'{3'd4, 4'b1000}, // B -...
		'{3'd4, 4'b1010}, // C -.-.
		'{3'd3, 4'b1000}, // D -..
		'{3'd1, 4'b0000}, // E .
		'{3'd4, 4'b0010}, // F ..-.
		'{3'd3, 4'b1100}, // G --.
		'{3'd4, 4'b0000}, // H ....
		'{3'd2, 4'b0000}, // I ..
		'{3'd4, 4'b0111}, // J .---
		'{3'd3, 4'b1010}, // K -.-
		'{3'd4, 4'b0100}, // L .-..
		'{3'd2, 4'b1100}, // M --
		'{3'd2, 4'b1000}, // N -.
		'{3'd3, 4'b1110}, // O ---
		'{3'd4, 4'b0110}, // P .--.
		'{3'd4, 4'b1101}, // Q --.-
		'{3'd3, 4'b0100}, // R .-.
		'{3'd3, 4'b0000}, // S ...
		'{3'd1, 4'b1000}, // T -
		'{3'd3, 4'b0010}, // U ..-
		'{3'd4, 4'b0001}, // V ...-
		'{3'd3, 4'b0110}, // W .--
		'{3'd4, 4'b1001}, // X -..-
		'{3'd4, 4'b1011}, // Y -.--
		'{3'd4, 4'b1100}  // Z --..
	};

	// Work for the back end: leading space segments, symbols, trailing newline
	typedef struct packed {
		logic [1:0] spaces;
		logic [2:0] syms;
		logic [3:0] dash;
		logic       eom;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/mcle_char_if.sv */
// Character input channel: valid/ready handshake with the message character.
// Depends on nothing.
`default_nettype none

interface mcle_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_message;

	modport source(output valid, output ch, output end_of_message, input ready);
	modport sink(input valid, input ch, input end_of_message, output ready);
endinterface

`default_nettype wire

/* rtl/mcle_seg_if.sv */
// LED segment output channel: valid/ready handshake with one timed segment.
// Depends on nothing.
`default_nettype none

interface mcle_seg_if;
	logic       valid;
	logic       ready;
	logic       led;
	logic [1:0] units;
	logic [2:0] text;
	logic       last_of_run;

	modport source(output valid, output led, output units, output text,
		output last_of_run, input ready);
	modport sink(input valid, input led, input units, input text,
		input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/mcle_front.sv */
// Front end: accepts characters, folds case, tracks the gap state and
// builds one command per character that produces segments. Uses mcle_pkg.
`default_nettype none

module mcle_front (
	input  logic            clk,
	input  logic            arst_n,
	mcle_char_if.sink       chars,
	output logic            push,
	output mcle_pkg::cmd_t  cmd,
	input  logic            full
);
	import mcle_pkg::*;

	logic       letter_seen_q;
	logic       word_gap_pending_q;
	logic [7:0] uc;
	logic       is_letter;
	logic       is_space;
	logic [4:0] idx;
	logic [7:0] idx_full;
	glyph_t     glyph;
	logic       accept;

	assign chars.ready = !full;
	assign accept      = chars.valid && chars.ready;

	always_comb begin
		if (chars.ch >= CHAR_LOWER_A && chars.ch <= CHAR_LOWER_Z) begin
			uc = chars.ch - CASE_OFFSET;
		end else begin
			uc = chars.ch;
		end
	end

	assign is_letter = (uc >= CHAR_UPPER_A) && (uc <= CHAR_UPPER_Z);
	assign is_space  = (uc == CHAR_SPACE);
	assign idx_full  = uc - CHAR_UPPER_A;
	assign idx       = idx_full[4:0];
	// only meaningful when is_letter, which keeps idx below the table size
	assign glyph     = is_letter ? GLYPH_TAB[idx] : '0;

	always_comb begin
		cmd.spaces = 2'd0;
		if (is_letter && letter_seen_q) begin
			cmd.spaces = word_gap_pending_q ? 2'd3 : 2'd1;
		end
		cmd.syms = glyph.len;
		cmd.dash = glyph.dash;
		cmd.eom  = chars.end_of_message;
	end

	assign push = accept && (is_letter || chars.end_of_message);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_seen_q      <= 1'b0;
			word_gap_pending_q <= 1'b0;
		end else if (accept) begin
			priority if (chars.end_of_message) begin
				letter_seen_q      <= 1'b0;
				word_gap_pending_q <= 1'b0;
			end else if (is_letter) begin
				letter_seen_q      <= 1'b1;
				word_gap_pending_q <= 1'b0;
			end else if (is_space && letter_seen_q) begin
				word_gap_pending_q <= 1'b1;
			end else begin
				// ignored character: gap state holds
				letter_seen_q      <= letter_seen_q;
				word_gap_pending_q <= word_gap_pending_q;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/mcle_queue.sv */
// Command queue between front and back ends, QDEPTH entries of cmd_t.
// Uses mcle_pkg.
`default_nettype none

module mcle_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mcle_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output mcle_pkg::cmd_t  head_cmd,
	output logic            nonempty
);
	import mcle_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign full     = (count_q == (QAW+1)'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/mcle_back.sv */
// Back end: emits the segments of each queued command into the output
// register, one per cycle unless stalled. Uses mcle_pkg, mcle_seg_if.
`default_nettype none

module mcle_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nonempty,
	input  mcle_pkg::cmd_t  q_cmd,
	output logic            q_pop,
	mcle_seg_if.source      segs
);
	import mcle_pkg::*;

	logic       busy_q;
	logic [1:0] spaces_q;
	logic [2:0] syms_q;
	logic [3:0] dash_q;
	logic       on_q;
	logic       nl_q;

	logic       out_valid_q;
	logic       led_q;
	logic [1:0] units_q;
	logic [2:0] text_q;
	logic       last_q;

	logic       seg_led;
	logic [1:0] seg_units;
	logic [2:0] seg_text;
	logic       seg_last;
	logic       advance;
	logic       load;

	always_comb begin
		seg_led   = 1'b0;
		seg_units = UNITS_DOT;
		seg_text  = TXT_NONE;
		seg_last  = 1'b0;
		priority if (spaces_q != 2'd0) begin
			seg_text = TXT_SPACE;
			seg_last = (spaces_q == 2'd1) && (syms_q == 3'd0) && !nl_q;
		end else if (syms_q != 3'd0) begin
			if (on_q) begin
				seg_led   = 1'b1;
				seg_units = dash_q[3] ? UNITS_DASH : UNITS_DOT;
				seg_text  = dash_q[3] ? TXT_DASH : TXT_DOT;
			end else begin
				seg_last = (syms_q == 3'd1) && !nl_q;
			end
		end else begin
			seg_units = UNITS_NONE;
			seg_text  = TXT_NEWLINE;
			seg_last  = 1'b1;
		end
	end

	assign advance = busy_q && (!out_valid_q || segs.ready);
	assign load    = q_nonempty && (!busy_q || (advance && seg_last));
	assign q_pop   = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			spaces_q <= 2'd0;
			syms_q   <= 3'd0;
			dash_q   <= 4'd0;
			on_q     <= 1'b0;
			nl_q     <= 1'b0;
		end else if (load) begin
			busy_q   <= 1'b1;
			spaces_q <= q_cmd.spaces;
			syms_q   <= q_cmd.syms;
			dash_q   <= q_cmd.dash;
			on_q     <= 1'b1;
			nl_q     <= q_cmd.eom;
		end else if (advance) begin
			priority if (seg_last) begin
				busy_q <= 1'b0;
				nl_q   <= 1'b0;
			end else if (spaces_q != 2'd0) begin
				spaces_q <= spaces_q - 1'b1;
			end else if (syms_q != 3'd0) begin
				if (on_q) begin
					on_q <= 1'b0;
				end else begin
					on_q   <= 1'b1;
					syms_q <= syms_q - 1'b1;
					dash_q <= {dash_q[2:0], 1'b0};
				end
			end else begin
				nl_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (segs.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_q   <= seg_led;
			units_q <= seg_units;
			text_q  <= seg_text;
			last_q  <= seg_last;
		end
	end

	assign segs.valid       = out_valid_q;
	assign segs.led         = led_q;
	assign segs.units       = units_q;
	assign segs.text        = text_q;
	assign segs.last_of_run = last_q;

endmodule

`default_nettype wire

/* rtl/morse_code_led_encoder_core.sv */
// Top level of the Morse code LED encoder: front end, command queue, back end.
// Uses mcle_pkg, mcle_char_if, mcle_seg_if, mcle_front, mcle_queue, mcle_back.
`default_nettype none

// Takes one ASCII character per transaction on chars and returns its timed LED
// segments on segs, one segment per cycle while segs is ready. A character that
// produces segments is worked off by the back-end sequencer one segment at a
// time (1 to 12: up to three spaces, two per dot or dash, one newline), after
// its command is loaded; characters with no segments are handled at the front
// end only. A four-entry command queue lets the front keep taking characters
// while the sequencer works. The single output register holds a segment until
// it is taken and the sequencer stalls while it waits; the next segment forms
// in the cycle the previous one leaves. The sustained rate is set by the
// sequencer emitting one segment per cycle while the output is not stalled.
module morse_code_led_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	mcle_char_if.sink  chars,
	mcle_seg_if.source segs
);
	import mcle_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_pop;
	cmd_t head_cmd;
	logic q_nonempty;

	mcle_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.push   (push),
		.cmd    (push_cmd),
		.full   (q_full)
	);

	mcle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.nonempty (q_nonempty)
	);

	mcle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_cmd      (head_cmd),
		.q_pop      (q_pop),
		.segs       (segs)
	);

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !chars.ready)
		else $error("character taken while command queue full");

	a_newline_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(segs.valid && segs.text == TXT_NEWLINE) |-> segs.last_of_run)
		else $error("newline segment not marked last");

	a_led_on_is_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		(segs.valid && segs.led) |-> (segs.text == TXT_DOT || segs.text == TXT_DASH))
		else $error("lit segment without dot or dash");

endmodule

`default_nettype wire
